>>> rtl/lmcs_pkg.sv
// ----------------------------------------------------------------------------
// lmcs_pkg: shared types and constants for the led matrix column scanner
// Opcodes, field widths, bank decode and row count helpers.
// ----------------------------------------------------------------------------
package lmcs_pkg;

  localparam int COL_W    = 5;
  localparam int ROW_W    = 3;
  localparam int ROWS     = 8;
  localparam int PAT_W    = 8;
  localparam int DLY_W    = 11;
  localparam int DPR_W    = 8;
  localparam int CNT_W    = 4;
  localparam int BANK_W   = 2;

  // bank boundaries
  localparam logic [COL_W-1:0] BANK0_LAST = 5'd7;
  localparam logic [COL_W-1:0] BANK1_LAST = 5'd15;
  localparam logic [COL_W-1:0] BANK2_LAST = 5'd19;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_SCAN  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } lmcs_op_t;

  typedef enum logic [BANK_W-1:0] {
    BANK_LOW  = 2'd0,
    BANK_MID  = 2'd1,
    BANK_HIGH = 2'd2,
    BANK_OFF  = 2'd3
  } lmcs_bank_t;

  // contents of one column entry
  typedef struct packed {
    logic [PAT_W-1:0] pat;
    logic [DLY_W-1:0] dly;
  } lmcs_entry_t;

  // number of lit rows in a column pattern
  function automatic logic [CNT_W-1:0] lit_count(input logic [PAT_W-1:0] pat);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int b = 0; b < ROWS; b++) begin
      n = n + CNT_W'(pat[b]);
    end
    return n;
  endfunction

  // bank enable code for a column
  function automatic lmcs_bank_t bank_of(input logic [COL_W-1:0] col);
    lmcs_bank_t b;
    if (col <= BANK0_LAST) begin
      b = BANK_LOW;
    end else if (col <= BANK1_LAST) begin
      b = BANK_MID;
    end else if (col <= BANK2_LAST) begin
      b = BANK_HIGH;
    end else begin
      b = BANK_OFF;
    end
    return b;
  endfunction

endpackage

>>> rtl/lmcs_frame_store.sv
// ----------------------------------------------------------------------------
// lmcs_frame_store: column frame store
// One write port and one registered read port over the per-column pattern
// and off delay, a valid bit per column that a clear resets, and a
// bypass from a write to a read of the same column in the same cycle.
// ----------------------------------------------------------------------------
module lmcs_frame_store
  import lmcs_pkg::*;
#(
  parameter int NUM_COLUMNS = 20,
  parameter int IDX_W       = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output lmcs_entry_t      rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  lmcs_entry_t      wr_data
);

  lmcs_entry_t            mem [NUM_COLUMNS];
  logic [NUM_COLUMNS-1:0] valid;
  lmcs_entry_t            rd_q;
  logic                   rd_valid;
  logic                   wr_go;
  logic                   fwd;

  // a clear is younger than any write retiring with it
  assign wr_go = wr_en && !clear;
  assign fwd   = wr_go && (wr_addr == rd_addr);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_go) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read with write bypass
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (fwd) begin
        rd_q     <= wr_data;
        rd_valid <= 1'b1;
      end else begin
        rd_q     <= mem[rd_addr];
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // a column never written since clear reads as dark
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

>>> rtl/led_matrix_column_scanner_core.sv
// ----------------------------------------------------------------------------
// led_matrix_column_scanner_core: multiplexed led matrix column scanner
// Column frame store with pixel writes, scan steps and a whole-frame clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_ready) carry an opcode and pixel fields. A pixel
//   write sets or clears one row bit and, unless all rows go dark, refreshes
//   that column's off delay; a clear wipes the frame and the scan pointer;
//   a scan step produces one output word (out_valid/out_ready) for the column
//   under the pointer and advances the pointer, wrapping at NUM_COLUMNS.
//   cfg_we/cfg_data write delay_per_dark_row; write it only while idle.
// Timing:
//   One word accepted per cycle while in_ready is high. A scan word is
//   registered in the read stage, along with its frame store read, when it
//   is accepted; the output register then loads from the read stage once
//   the output can take it. Pixel writes update the store in the cycle
//   after acceptance; a following word reading that column is bypassed, so
//   back-to-back traffic sees every write.
// Reset and stall:
//   rst clears the frame (per-column valid bits), the pointer, the delay
//   register and the pipeline. When out_valid is high and out_ready is low,
//   a scan word waits in the read stage and in_ready drops until it can move.
// ----------------------------------------------------------------------------
module led_matrix_column_scanner_core
  import lmcs_pkg::*;
#(
  parameter int NUM_COLUMNS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [DPR_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [COL_W-1:0]  pixel_column,
  input  logic [ROW_W-1:0]  pixel_row,
  input  logic              pixel_on,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COL_W-1:0]  scan_column,
  output logic [PAT_W-1:0]  row_bits,
  output logic [ROW_W-1:0]  decoder_select,
  output logic [BANK_W-1:0] bank_enable,
  output logic [DLY_W-1:0]  off_delay
);

  localparam int IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLUMNS - 1);
  localparam logic [COL_W-1:0] NCOL     = COL_W'(NUM_COLUMNS);

  logic [DPR_W-1:0] delay_per_dark_row;
  logic [COL_W-1:0] scan_pointer;

  // read stage registers
  logic             s1_valid;
  logic             s1_scan;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_on;

  lmcs_op_t    op;
  logic        accept;
  logic        acc_pixel;
  logic        acc_scan;
  logic        acc_clear;
  logic        s1_advance;
  logic        out_load;
  logic [COL_W-1:0] rd_col;
  lmcs_entry_t rd_data;
  lmcs_entry_t wr_data;
  logic        wr_en;
  logic [PAT_W-1:0] new_pat;
  logic [CNT_W-1:0] dark_rows;
  logic [CNT_W+DPR_W-1:0] dark_prod;

  // input decode
  assign op        = lmcs_op_t'(opcode);
  assign accept    = in_valid && in_ready;
  assign acc_pixel = accept && (op == OP_PIXEL) && (pixel_column < NCOL);
  assign acc_scan  = accept && (op == OP_SCAN);
  assign acc_clear = accept && (op == OP_CLEAR);

  // pipeline flow
  assign out_load   = s1_valid && s1_scan && (!out_valid || out_ready);
  assign s1_advance = !s1_valid || !s1_scan || out_load;
  assign in_ready   = s1_advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_per_dark_row <= '0;
    end else if (cfg_we) begin
      delay_per_dark_row <= cfg_data;
    end
  end

  // scan pointer, moved at acceptance
  always_ff @(posedge clk) begin
    if (rst || acc_clear) begin
      scan_pointer <= '0;
    end else if (acc_scan) begin
      scan_pointer <= (scan_pointer >= LAST_COL) ? '0 : scan_pointer + 1'b1;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= acc_pixel || acc_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_scan <= acc_scan;
      s1_col  <= rd_col;
      s1_row  <= pixel_row;
      s1_on   <= pixel_on;
    end
  end

  assign rd_col = acc_scan ? scan_pointer : pixel_column;

  // pixel update and off delay compensation
  always_comb begin
    new_pat = rd_data.pat;
    new_pat[s1_row] = s1_on;
  end

  assign dark_rows = CNT_W'(ROWS) - lit_count(new_pat);
  assign dark_prod = dark_rows * delay_per_dark_row;
  assign wr_en     = s1_valid && !s1_scan;

  always_comb begin
    wr_data.pat = new_pat;
    wr_data.dly = (new_pat != '0) ? dark_prod[DLY_W-1:0] : rd_data.dly;
  end

  lmcs_frame_store #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (acc_clear),
    .rd_en   (acc_pixel || acc_scan),
    .rd_addr (rd_col[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_col[IDX_W-1:0]),
    .wr_data (wr_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      scan_column    <= s1_col;
      row_bits       <= rd_data.pat;
      decoder_select <= s1_col[ROW_W-1:0];
      bank_enable    <= bank_of(s1_col);
      off_delay      <= rd_data.dly;
    end
  end

  // checks
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    scan_pointer < NCOL)
    else $error("scan pointer out of range");

  a_clear_ptr: assert property (@(posedge clk) disable iff (rst)
    acc_clear |=> (scan_pointer == '0) && !s1_valid)
    else $error("clear did not reset pointer and read stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_scan && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while a scan word is blocked");

  a_scan_out: assert property (@(posedge clk) disable iff (rst)
    acc_scan && s1_advance && !(s1_valid && s1_scan) && (!out_valid || out_ready)
      |=> s1_valid && s1_scan)
    else $error("accepted scan word lost from read stage");

endmodule
